[src/tdpt_pkg.sv]
// Package for the trial-division prime test.
// Holds widths, the first divisor and the controller/datapath command and status types.
// No dependencies.
package tdpt_pkg;

	localparam int NUMBER_BITS   = 16;
	localparam int CNT_W         = (NUMBER_BITS > 1) ? $clog2(NUMBER_BITS) : 1;
	localparam int SQ_W          = NUMBER_BITS + 2;
	localparam int IN_TDATA_W    = ((NUMBER_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W   = 8;
	localparam int FIRST_DIVISOR = 2;

	typedef struct packed {
		logic load;      // take a new number, restart divisor at two
		logic start_div; // clear remainder, load dividend shift register
		logic step;      // one restoring division step
		logic next_div;  // advance divisor and its square
	} dp_cmd_t;

	typedef struct packed {
		logic lt2;       // number below two
		logic sq_gt_n;   // divisor squared exceeds number
		logic div_last;  // current step is the final one
		logic rem_zero;  // remainder is zero
	} dp_status_t;

endpackage

[src/tdpt_dp.sv]
// Datapath of the trial-division prime test.
// Holds number, divisor, divisor square and a bit-serial restoring remainder unit.
// Depends on tdpt_pkg.
module tdpt_dp
	import tdpt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [NUMBER_BITS-1:0] number,
	input  dp_cmd_t                cmd,
	output dp_status_t             status
);

	logic [NUMBER_BITS-1:0] n_q;
	logic [NUMBER_BITS-1:0] d_q;
	logic [SQ_W-1:0]        sq_q;
	logic [NUMBER_BITS-1:0] rem_q;
	logic [NUMBER_BITS-1:0] sh_q;
	logic [CNT_W-1:0]       cnt_q;

	logic [NUMBER_BITS:0]   trial;
	logic [NUMBER_BITS:0]   diff;
	logic                   fits;

	assign trial = {rem_q, sh_q[NUMBER_BITS-1]};
	assign diff  = trial - {1'b0, d_q};
	assign fits  = (trial >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start_div) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q  <= number;
			d_q  <= NUMBER_BITS'(FIRST_DIVISOR);
			sq_q <= SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
		end else if (cmd.next_div) begin
			d_q  <= d_q + NUMBER_BITS'(1);
			sq_q <= sq_q + {1'b0, d_q, 1'b0} + SQ_W'(1);
		end
		if (cmd.start_div) begin
			rem_q <= '0;
			sh_q  <= n_q;
		end else if (cmd.step) begin
			rem_q <= fits ? diff[NUMBER_BITS-1:0] : trial[NUMBER_BITS-1:0];
			sh_q  <= {sh_q[NUMBER_BITS-2:0], 1'b0};
		end
	end

	assign status.lt2      = (n_q < NUMBER_BITS'(FIRST_DIVISOR));
	assign status.sq_gt_n  = (sq_q > {2'b00, n_q});
	assign status.div_last = (cnt_q == CNT_W'(NUMBER_BITS - 1));
	assign status.rem_zero = (rem_q == '0);

endmodule

[src/tdpt_ctrl.sv]
// Controller of the trial-division prime test.
// Sequences load, divisor checks and division steps; owns the output register.
// Depends on tdpt_pkg.
module tdpt_ctrl
	import tdpt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic       m_is_prime,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_TEST  = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       res_q;
	logic       res_d;
	logic       m_tvalid_q;
	logic       m_is_prime_q;
	logic       slot_free;
	logic       in_beat;

	assign s_tready   = (state_q == ST_IDLE);
	assign in_beat    = s_tvalid && s_tready;
	assign slot_free  = !m_tvalid_q || m_tready;
	assign m_tvalid   = m_tvalid_q;
	assign m_is_prime = m_is_prime_q;

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.lt2) begin
					res_d   = 1'b0;
					state_d = ST_FIN;
				end else if (status.sq_gt_n) begin
					res_d   = 1'b1;
					state_d = ST_FIN;
				end else begin
					cmd.start_div = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (status.div_last) begin
					state_d = ST_TEST;
				end
			end
			ST_TEST: begin
				if (status.rem_zero) begin
					res_d   = 1'b0;
					state_d = ST_FIN;
				end else begin
					cmd.next_div = 1'b1;
					state_d      = ST_CHECK;
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			res_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (state_q == ST_FIN && slot_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && slot_free) begin
			m_is_prime_q <= res_q;
		end
	end

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> state_q == ST_CHECK)
		else $error("accepted beat did not start a check");

	a_last_step_to_test: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && status.div_last |=> state_q == ST_TEST)
		else $error("division did not end in test");

	a_advance_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.next_div |-> !status.rem_zero)
		else $error("divisor advanced on exact division");

	a_fin_drives_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && slot_free |=> m_tvalid_q && state_q == ST_IDLE)
		else $error("finished result not presented");

endmodule

[src/trial_division_prime_test.sv]
// Top level of the trial-division prime test: stream ports, controller and datapath.
// Each divisor tried costs a bit-serial remainder over the NUMBER_BITS bits of the number;
// at most 254 divisors are tried. One number at a time: no new input beat is taken until
// the result of the last one is registered for output. Reset: arst_n clears control and
// the output valid; number and divisor registers load on each accepted beat.
module trial_division_prime_test
	import tdpt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [NUMBER_BITS-1:0] number
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [0] is_prime
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       is_prime;

	tdpt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_is_prime (is_prime),
		.cmd        (cmd),
		.status     (status)
	);

	tdpt_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.number (s_axis_tdata[NUMBER_BITS-1:0]),
		.cmd    (cmd),
		.status (status)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W-1){1'b0}}, is_prime};

endmodule
